/* rtl/fbl_pkg.sv */
`default_nettype none

package fbl_pkg;

  // request kinds carried in tuser
  localparam logic [1:0] REQ_LINE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_FILL  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [7:0] FILL_SET = 8'hFF;
  localparam logic [7:0] FILL_CLR = 8'h00;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 16;

endpackage

`default_nettype wire

/* rtl/framebuffer_line_plotter.sv */
`default_nettype none

// Monochrome page-organized framebuffer with a Bresenham line engine. Byte
// page * SCREEN_WIDTH + x of the single-port store holds column x of page y/8,
// bit y&7 is pixel (x, y). The block takes one request at a time and answers
// each with one item carrying read_data and dirty_mask. A read goes through
// ST_READ and ST_FINISH, a dirty-mask take goes straight to ST_FINISH, a fill
// writes one store byte per cycle in ST_FILL, and a line runs ST_SETUP1 and
// ST_SETUP2, then one ST_PLOT_A/ST_PLOT_B pair per major step, then ST_FINISH.
// Each plotted pixel is a read-modify-write on the one store port (read
// cycle, then write cycle), and one shared adder carries the error term
// through both halves of the step. Off-screen pixels still walk but do not
// touch the store or the dirty mask. Store contents are undefined after reset
// until the first fill. A finished result is held in an output register, so
// the next request is accepted while the previous result waits.
module framebuffer_line_plotter
  import fbl_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH = 128,
  parameter int unsigned PAGE_COUNT   = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // start_x[7:0], start_y[15:8], end_x[23:16], end_y[31:24], pen_color[32],
  // byte_address[42:33], zero[47:43]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // req_type[1:0]
  input  wire logic [1:0]            s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // read_data[7:0], dirty_mask[15:8]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o
);

  localparam int unsigned DEPTH     = SCREEN_WIDTH * PAGE_COUNT;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned HEIGHT    = PAGE_COUNT * 8;
  localparam logic [7:0]  ALL_PAGES = 8'(8'hFF >> (8 - PAGE_COUNT));

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP1 = 3'd1;
  localparam logic [2:0] ST_SETUP2 = 3'd2;
  localparam logic [2:0] ST_PLOT_A = 3'd3;
  localparam logic [2:0] ST_PLOT_B = 3'd4;
  localparam logic [2:0] ST_FILL   = 3'd5;
  localparam logic [2:0] ST_READ   = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0] state_q, state_d;

  // captured request
  logic [1:0] type_q;
  logic [7:0] sx_q, sy_q, ex_q, ey_q;
  logic       pen_q;
  logic [9:0] addr_q;

  // line walk registers
  logic [7:0]        adx_q, ady_q;
  logic              steep_q;
  logic              up_q;
  logic [7:0]        m_q, me_q, n_q;
  logic [7:0]        dx_q, dy_q;
  logic signed [9:0] err_q;

  logic [AW-1:0] fill_cnt_q;
  logic [7:0]    dirty_q;
  logic [7:0]    rd_q;

  logic                  out_valid_q;
  logic [7:0]            out_rd_q, out_mask_q;

  // ---------------------------------------------------------------------------
  // input side: ready only between requests
  // ---------------------------------------------------------------------------
  logic in_fire;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // output register frees when empty or taken this cycle
  logic can_load;
  assign can_load = !out_valid_q || m_axis_tready_i;

  // ---------------------------------------------------------------------------
  // setup arithmetic
  // ---------------------------------------------------------------------------
  logic [8:0] dxs, dys;
  logic       steep_c;
  logic [7:0] ma_c, mb_c, na_c, nb_c;
  logic       swap_c;

  assign dxs = {1'b0, ex_q} - {1'b0, sx_q};
  assign dys = {1'b0, ey_q} - {1'b0, sy_q};

  assign steep_c = ady_q > adx_q;
  assign ma_c    = steep_c ? sy_q : sx_q;
  assign mb_c    = steep_c ? ey_q : ex_q;
  assign na_c    = steep_c ? sx_q : sy_q;
  assign nb_c    = steep_c ? ex_q : ey_q;
  assign swap_c  = ma_c > mb_c;

  // ---------------------------------------------------------------------------
  // current pixel and its store address
  // ---------------------------------------------------------------------------
  logic [7:0]  px, py;
  logic        on_screen;
  logic [15:0] pix_lin;
  logic [7:0]  pix_bit;

  assign px        = steep_q ? n_q : m_q;
  assign py        = steep_q ? m_q : n_q;
  assign on_screen = ({1'b0, px} < 9'(SCREEN_WIDTH)) && ({1'b0, py} < 9'(HEIGHT));
  assign pix_lin   = 16'(py[7:3]) * 16'(SCREEN_WIDTH) + 16'(px);
  assign pix_bit   = 8'(8'd1 << py[2:0]);

  // shared error adder: subtract dy in the read half, add dx in the write half
  logic signed [9:0] err_op, err_sum;
  assign err_op  = (state_q == ST_PLOT_A) ? -$signed({2'b00, dy_q}) : $signed({2'b00, dx_q});
  assign err_sum = err_q + err_op;

  // ---------------------------------------------------------------------------
  // single store port
  // ---------------------------------------------------------------------------
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [11:0]   rd_addr_ext;
  logic          rd_in_range;

  assign rd_addr_ext = 12'(addr_q);
  assign rd_in_range = rd_addr_ext < 12'(DEPTH);

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = pix_lin[AW-1:0];
    mem_wdata = pen_q ? (rd_q | pix_bit) : (rd_q & ~pix_bit);
    case (state_q)
      ST_PLOT_A: begin
        mem_re = on_screen;
      end
      ST_PLOT_B: begin
        mem_we = on_screen;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_addr  = fill_cnt_q;
        mem_wdata = pen_q ? FILL_SET : FILL_CLR;
      end
      ST_READ: begin
        mem_re   = rd_in_range;
        mem_addr = rd_addr_ext[AW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  logic [7:0] store_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= store_mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser_i)
            REQ_LINE: state_d = ST_SETUP1;
            REQ_READ: state_d = ST_READ;
            REQ_FILL: state_d = ST_FILL;
            default:  state_d = ST_FINISH;
          endcase
        end
      end
      ST_SETUP1: state_d = ST_SETUP2;
      ST_SETUP2: state_d = ST_PLOT_A;
      ST_PLOT_A: state_d = ST_PLOT_B;
      ST_PLOT_B: state_d = (m_q == me_q) ? ST_FINISH : ST_PLOT_A;
      ST_FILL: begin
        if (fill_cnt_q == AW'(DEPTH - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_READ: state_d = ST_FINISH;
      ST_FINISH: begin
        if (can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dirty_q     <= 8'd0;
      out_valid_q <= 1'b0;
      fill_cnt_q  <= '0;
    end else begin
      state_q <= state_d;
      // result register: load on finish, drop once taken
      if (state_q == ST_FINISH && can_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          fill_cnt_q <= '0;
        end
        ST_PLOT_B: begin
          if (on_screen) begin
            dirty_q <= dirty_q | 8'(8'd1 << py[5:3]);
          end
        end
        ST_FILL: begin
          fill_cnt_q <= fill_cnt_q + AW'(1);
          dirty_q    <= dirty_q | ALL_PAGES;
        end
        ST_FINISH: begin
          if (can_load && type_q == REQ_CLEAR) begin
            dirty_q <= 8'd0;
          end
        end
        default: begin
          dirty_q <= dirty_q;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      type_q <= s_axis_tuser_i;
      sx_q   <= s_axis_tdata_i[7:0];
      sy_q   <= s_axis_tdata_i[15:8];
      ex_q   <= s_axis_tdata_i[23:16];
      ey_q   <= s_axis_tdata_i[31:24];
      pen_q  <= s_axis_tdata_i[32];
      addr_q <= s_axis_tdata_i[42:33];
    end
    case (state_q)
      ST_SETUP1: begin
        adx_q <= dxs[8] ? 8'(-dxs) : dxs[7:0];
        ady_q <= dys[8] ? 8'(-dys) : dys[7:0];
      end
      ST_SETUP2: begin
        // walk from the lower to the higher major coordinate
        steep_q <= steep_c;
        m_q     <= swap_c ? mb_c : ma_c;
        me_q    <= swap_c ? ma_c : mb_c;
        n_q     <= swap_c ? nb_c : na_c;
        up_q    <= swap_c ? (nb_c < na_c) : (na_c < nb_c);
        dx_q    <= steep_c ? ady_q : adx_q;
        dy_q    <= steep_c ? adx_q : ady_q;
        err_q   <= $signed({3'b000, (steep_c ? ady_q[7:1] : adx_q[7:1])});
      end
      ST_PLOT_A: begin
        err_q <= err_sum;
      end
      ST_PLOT_B: begin
        if (err_q < 0) begin
          err_q <= err_sum;
          n_q   <= n_q + (up_q ? 8'd1 : 8'hFF);
        end
        if (m_q != me_q) begin
          m_q <= m_q + 8'd1;
        end
      end
      ST_FINISH: begin
        if (can_load) begin
          out_rd_q   <= (type_q == REQ_READ && rd_in_range) ? rd_q : 8'd0;
          out_mask_q <= dirty_q;
        end
      end
      default: begin
        err_q <= err_q;
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_mask_q, out_rd_q};

`ifndef SYNTHESIS
  a_clear_empties_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && can_load && type_q == REQ_CLEAR) |=> (dirty_q == 8'd0))
    else $error("dirty mask not cleared after take");

  a_plot_in_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PLOT_B && mem_we) |-> (pix_lin < 16'(DEPTH)))
    else $error("pixel write outside store");

  a_walk_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PLOT_A || state_q == ST_PLOT_B) |-> (m_q <= me_q))
    else $error("line walk passed its end");

  a_fill_marks_all : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && state_d == ST_FINISH) |=> ((dirty_q & ALL_PAGES) == ALL_PAGES))
    else $error("fill did not mark all pages dirty");
`endif

endmodule

`default_nettype wire

/* tb/tb_framebuffer_line_plotter.sv */
module tb_framebuffer_line_plotter;
  timeunit 1ns;
  timeprecision 1ps;

  import fbl_pkg::*;

  localparam int unsigned SCREEN_W    = 128;
  localparam int unsigned PAGES       = 8;
  localparam int unsigned SCREEN_H    = PAGES * 8;
  localparam int unsigned STORE_BYTES = SCREEN_W * PAGES;
  localparam logic [7:0]  ALL_PAGES   = 8'hFF >> (8 - PAGES);
  // the limit lies well above the longest fill, leaving plenty of room for stalls
  localparam int          STALL_LIMIT = 20000;
  localparam int          DRAIN_WAIT  = 16;
  localparam int          PHASE_ITEMS = 250;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] sx;
    logic [7:0] sy;
    logic [7:0] ex;
    logic [7:0] ey;
    logic       pen;
    logic [9:0] addr;
  } draw_req_t;

  typedef struct packed {
    logic [7:0] dirty_mask;
    logic [7:0] read_data;
  } plot_result_t;

  // mirror of the framebuffer and dirty mask, queues the answer of each request
  class fb_mirror;
    bit [7:0]     frame [STORE_BYTES];
    bit [7:0]     dirty;
    plot_result_t pending_answers[$];
    int           errors;

    function new();
      foreach (frame[i]) frame[i] = 8'h00;
      dirty  = 8'h00;
      errors = 0;
    endfunction

    function int magnitude(int v);
      return (v < 0) ? -v : v;
    endfunction

    function void plot_pixel(int x, int y, bit pen);
      int idx;
      if (x < 0 || y < 0 || x >= SCREEN_W || y >= SCREEN_H) return;
      dirty = dirty | (8'h01 << (y / 8));
      idx = (y / 8) * SCREEN_W + x;
      if (pen) frame[idx] = frame[idx] | (8'h01 << (y % 8));
      else frame[idx] = frame[idx] & ~(8'h01 << (y % 8));
    endfunction

    function void draw_line(int ax, int ay, int bx, int by, bit pen);
      bit steep;
      int t, dx, dy, err, stp, x, y;
      steep = magnitude(by - ay) > magnitude(bx - ax);
      if (steep) begin
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      dx  = bx - ax;
      dy  = magnitude(by - ay);
      err = dx / 2;
      stp = (ay < by) ? 1 : -1;
      y   = ay;
      for (x = ax; x <= bx; x++) begin
        if (steep) plot_pixel(y, x, pen);
        else plot_pixel(x, y, pen);
        err -= dy;
        if (err < 0) begin
          y   += stp;
          err += dx;
        end
      end
    endfunction

    function void note_request(draw_req_t r);
      plot_result_t ans;
      ans.read_data = 8'h00;
      case (r.kind)
        REQ_LINE: begin
          draw_line(int'(r.sx), int'(r.sy), int'(r.ex), int'(r.ey), r.pen);
          ans.dirty_mask = dirty;
        end
        REQ_READ: begin
          if (r.addr < STORE_BYTES) ans.read_data = frame[r.addr];
          ans.dirty_mask = dirty;
        end
        REQ_FILL: begin
          foreach (frame[i]) frame[i] = r.pen ? FILL_SET : FILL_CLR;
          dirty          = dirty | ALL_PAGES;
          ans.dirty_mask = dirty;
        end
        default: begin
          ans.dirty_mask = dirty;
          dirty          = 8'h00;
        end
      endcase
      pending_answers.push_back(ans);
    endfunction

    task report(string msg);
      errors++;
      // keep the log bounded on a badly broken block
      if (errors <= 100) $display("%0t ns: %s", $time, msg);
    endtask

    task check_result(logic [OUT_DATA_W-1:0] word);
      plot_result_t got, want;
      got = word;
      if (pending_answers.size() == 0) begin
        report($sformatf("unexpected result %04h", word));
        return;
      end
      want = pending_answers.pop_front();
      if (got.read_data !== want.read_data)
        report($sformatf("read_data %02h, want %02h", got.read_data, want.read_data));
      if (got.dirty_mask !== want.dirty_mask)
        report($sformatf("dirty_mask %02h, want %02h", got.dirty_mask, want.dirty_mask));
    endtask

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = REQ_LINE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  fb_mirror mirror;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       quiet_cycles  = 0;
  // last line start, used to aim reads at bytes that lines touched
  logic [7:0] last_x = 8'd0;
  logic [7:0] last_y = 8'd0;

  framebuffer_line_plotter #(
    .SCREEN_WIDTH (SCREEN_W),
    .PAGE_COUNT   (PAGES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: values read here are the ones seen at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        mirror.note_request({s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                             s_axis_tdata[23:16], s_axis_tdata[31:24],
                             s_axis_tdata[32], s_axis_tdata[42:33]});
      if (m_axis_tvalid && m_axis_tready)
        mirror.check_result(m_axis_tdata);
    end
  end

  // watchdog on cycles in which neither side moves an item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic draw_req_t make_req(logic [1:0] kind, int sx, int sy, int ex, int ey,
                                         bit pen, int addr);
    draw_req_t r;
    r.kind = kind;
    r.sx   = sx[7:0];
    r.sy   = sy[7:0];
    r.ex   = ex[7:0];
    r.ey   = ey[7:0];
    r.pen  = pen;
    r.addr = addr[9:0];
    return r;
  endfunction

  // hold the item until the block takes it; returns at the accepting edge
  task automatic send_request(input draw_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {5'b0, r.addr, r.pen, r.ey, r.ex, r.sy, r.sx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // mostly lines and reads, a few mask takes and rare fills (they are slow)
  task automatic send_random_request();
    draw_req_t r;
    int        pick, shape;
    r      = make_req(REQ_LINE, 0, 0, 0, 0, 1'b1, 0);
    r.sx   = 8'($urandom_range(255));
    r.sy   = 8'($urandom_range(255));
    r.ex   = 8'($urandom_range(255));
    r.ey   = 8'($urandom_range(255));
    r.pen  = ($urandom_range(99) < 75);
    r.addr = 10'($urandom_range(1023));
    pick   = $urandom_range(99);
    if (pick < 55) begin
      shape = $urandom_range(99);
      if (shape < 40) begin
        // short segment, sometimes wrapping past the edge
        r.sx = 8'($urandom_range(SCREEN_W - 1));
        r.sy = 8'($urandom_range(SCREEN_H - 1));
        r.ex = r.sx + 8'($urandom_range(16)) - 8'd8;
        r.ey = r.sy + 8'($urandom_range(16)) - 8'd8;
      end else if (shape < 85) begin
        // on or just past the screen
        r.sx = 8'($urandom_range(SCREEN_W + 8));
        r.sy = 8'($urandom_range(SCREEN_H + 6));
        r.ex = 8'($urandom_range(SCREEN_W + 8));
        r.ey = 8'($urandom_range(SCREEN_H + 6));
      end
      last_x = r.sx;
      last_y = r.sy;
    end else if (pick < 85) begin
      r.kind = REQ_READ;
      if ($urandom_range(1) && last_x < SCREEN_W && last_y < SCREEN_H)
        r.addr = 10'((last_y / 8) * SCREEN_W + last_x);
    end else if (pick < 97) begin
      r.kind = REQ_CLEAR;
    end else begin
      r.kind = REQ_FILL;
    end
    send_request(r);
  endtask

  initial begin
    mirror = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 34;
    recv_idle_pct = 70;

    // directed: mask take at reset, a line drawn into the unwritten store, then fill
    send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 1'b0, 0));
    send_request(make_req(REQ_LINE, 0, 0, 255, 255, 1'b1, 0));
    send_request(make_req(REQ_FILL, 0, 0, 0, 0, 1'b0, 0));
    send_request(make_req(REQ_CLEAR, 255, 255, 255, 255, 1'b1, 1023));
    // full diagonal, then the corner byte
    send_request(make_req(REQ_LINE, 0, 0, 127, 63, 1'b1, 0));
    send_request(make_req(REQ_READ, 0, 0, 0, 0, 1'b0, 0));
    // horizontal running off the right edge, vertical drawn bottom up
    send_request(make_req(REQ_LINE, 0, 10, 255, 10, 1'b1, 0));
    send_request(make_req(REQ_LINE, 5, 255, 5, 0, 1'b1, 0));
    // single on-screen pixel, single off-screen pixel
    send_request(make_req(REQ_LINE, 127, 63, 127, 63, 1'b1, 0));
    send_request(make_req(REQ_LINE, 200, 200, 200, 200, 1'b1, 0));
    send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 1'b0, 0));
    // entirely off screen: mask must stay empty
    send_request(make_req(REQ_LINE, 128, 64, 255, 255, 1'b1, 0));
    // falling slope and a steep line walked backwards
    send_request(make_req(REQ_LINE, 0, 63, 127, 0, 1'b1, 0));
    send_request(make_req(REQ_LINE, 100, 2, 90, 60, 1'b1, 0));
    send_request(make_req(REQ_READ, 0, 0, 0, 0, 1'b0, 1023));
    // clear pen erasing part of the horizontal line
    send_request(make_req(REQ_LINE, 0, 10, 60, 10, 1'b0, 0));
    send_request(make_req(REQ_READ, 0, 0, 0, 0, 1'b0, SCREEN_W + 30));
    send_request(make_req(REQ_READ, 0, 0, 0, 0, 1'b0, SCREEN_W + 100));
    send_request(make_req(REQ_FILL, 0, 0, 0, 0, 1'b1, 0));
    send_request(make_req(REQ_READ, 0, 0, 0, 0, 1'b0, 512));
    send_request(make_req(REQ_LINE, 3, 3, 250, 40, 1'b0, 0));
    send_request(make_req(REQ_READ, 0, 0, 0, 0, 1'b0, 3));
    send_request(make_req(REQ_CLEAR, 0, 0, 0, 0, 1'b0, 0));
    send_request(make_req(REQ_READ, 0, 0, 0, 0, 1'b0, 1023));

    repeat (PHASE_ITEMS) send_random_request();
    send_idle_pct = 70;
    recv_idle_pct = 34;
    repeat (PHASE_ITEMS) send_random_request();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (PHASE_ITEMS) send_random_request();
    s_axis_tvalid <= 1'b0;

    // the watchdog covers a result that never shows up
    while (mirror.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mirror.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* framebuffer_line_plotter.f */
rtl/fbl_pkg.sv
rtl/framebuffer_line_plotter.sv
tb/tb_framebuffer_line_plotter.sv
